// ===== hdl/servo_reply_frame_receiver_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the servo reply frame receiver
// Implication checks sampled on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef SERVO_REPLY_FRAME_RECEIVER_MACROS_SVH
`define SERVO_REPLY_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication
`define SRFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SRFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/srfr_pkg.sv =====
// ---------------------------------------------------------------------------
// srfr_pkg
// Shared codes and types of the servo reply frame receiver.
// ---------------------------------------------------------------------------
package srfr_pkg;

  localparam int unsigned IDX_W = 6;

  localparam logic [7:0] HDR_BYTE = 8'h55;
  localparam logic [7:0] MIN_LEN  = 8'd3;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_CSUM_ERR = 2'd1;
  localparam logic [1:0] KIND_LEN_ERR  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic accept;       // input transfer this cycle
    logic drain_start;  // good checksum taken, rewind the read counter
    logic load;         // move one buffered payload byte to the output
  } srfr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic frame_ok;     // current byte is a matching checksum
    logic out_free;     // output register can take a result
    logic run_last;     // read counter is on the last payload byte
  } srfr_stat_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       id;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             last;
  } srfr_result_t;

endpackage

// ===== hdl/srfr_ctrl.sv =====
// ---------------------------------------------------------------------------
// srfr_ctrl
// Receive / drain sequencer of the servo reply frame receiver.
// ---------------------------------------------------------------------------
module srfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  srfr_pkg::srfr_stat_t stat,
  output srfr_pkg::srfr_cmd_t  cmd
);
  import srfr_pkg::*;

  localparam logic [1:0] ST_RX   = 2'd0;  // taking bytes
  localparam logic [1:0] ST_RD   = 2'd1;  // first buffer read in flight
  localparam logic [1:0] ST_LOAD = 2'd2;  // streaming payload out

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready        = (state == ST_RX) && stat.out_free;
  assign cmd.accept      = in_valid && in_ready;
  assign cmd.drain_start = cmd.accept && stat.frame_ok;
  assign cmd.load        = (state == ST_LOAD) && stat.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RX: begin
        if (cmd.drain_start) state_next = ST_RD;
      end
      ST_RD: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (cmd.load && stat.run_last) state_next = ST_RX;
      end
      default: begin
        state_next = ST_RX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RX;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/srfr_datapath.sv =====
// ---------------------------------------------------------------------------
// srfr_datapath
// Frame tracking registers, payload buffer, checksum and output register.
// ---------------------------------------------------------------------------
module srfr_datapath #(
  parameter int unsigned BUF_BYTES = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             rx_byte,
  input  srfr_pkg::srfr_cmd_t    cmd,
  output srfr_pkg::srfr_stat_t   stat,
  input  logic                   out_ready,
  output logic                   out_valid,
  output srfr_pkg::srfr_result_t out_result
);
  import srfr_pkg::*;

  localparam int unsigned AW      = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam logic [7:0]  MAX_LEN = 8'(BUF_BYTES - 3);

  logic             header_seen;
  logic             in_frame;
  logic [IDX_W-1:0] byte_position;
  logic [7:0]       frame_length;
  logic [7:0]       running_sum;
  logic [7:0]       frame_id;
  logic [IDX_W-1:0] rd_cnt;
  logic [IDX_W-1:0] rd_cnt_next;
  logic [7:0]       rd_data;
  logic [7:0]       payload_store [BUF_BYTES];

  logic             at_id, at_len, in_body, at_csum;
  logic             len_short, len_long, csum_ok;
  logic             err_len, err_csum, load_any;
  logic [IDX_W-1:0] rd_addr_full;
  logic [7:0]       pos_ext;

  assign pos_ext   = 8'(byte_position);
  assign at_id     = in_frame && (byte_position == IDX_W'(2));
  assign at_len    = in_frame && (byte_position == IDX_W'(3));
  assign in_body   = in_frame && !at_id && !at_len && (pos_ext < (frame_length + 8'd2));
  assign at_csum   = in_frame && !at_id && !at_len && !in_body;
  assign len_short = rx_byte < MIN_LEN;
  assign len_long  = rx_byte > MAX_LEN;
  assign csum_ok   = at_csum && (rx_byte == ~running_sum);

  assign err_len  = cmd.accept && at_len && !len_short && len_long;
  assign err_csum = cmd.accept && at_csum && !csum_ok;
  assign load_any = cmd.load || err_len || err_csum;

  assign stat.frame_ok = csum_ok;
  assign stat.out_free = !out_valid || out_ready;
  assign stat.run_last = (8'(rd_cnt) + 8'd3) == frame_length;

  // prefetch: buffer is read at the index the counter takes next
  always_comb begin
    if (cmd.drain_start) begin
      rd_cnt_next = '0;
    end else if (cmd.load) begin
      rd_cnt_next = rd_cnt + IDX_W'(1);
    end else begin
      rd_cnt_next = rd_cnt;
    end
  end

  assign rd_addr_full = rd_cnt_next + IDX_W'(4);

  // payload buffer: written by frame position, read at run index + 4
  always_ff @(posedge clk) begin
    if (cmd.accept && in_body) begin
      payload_store[byte_position[AW-1:0]] <= rx_byte;
    end
    rd_data <= payload_store[rd_addr_full[AW-1:0]];
  end

  // frame tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      header_seen   <= 1'b0;
      in_frame      <= 1'b0;
      byte_position <= '0;
      frame_length  <= 8'd2;
      running_sum   <= '0;
      frame_id      <= '0;
    end else if (cmd.accept) begin
      if (!in_frame) begin
        if (rx_byte == HDR_BYTE) begin
          if (header_seen) begin
            header_seen   <= 1'b0;
            in_frame      <= 1'b1;
            byte_position <= IDX_W'(2);
            frame_length  <= 8'd2;
            running_sum   <= '0;
          end else begin
            header_seen <= 1'b1;
          end
        end else begin
          header_seen <= 1'b0;
        end
      end else if (at_id) begin
        frame_id      <= rx_byte;
        running_sum   <= rx_byte;
        byte_position <= IDX_W'(3);
      end else if (at_len) begin
        if (len_short || len_long) begin
          in_frame      <= 1'b0;
          byte_position <= '0;
        end else begin
          frame_length  <= rx_byte;
          running_sum   <= running_sum + rx_byte;
          byte_position <= IDX_W'(4);
        end
      end else if (in_body) begin
        running_sum   <= running_sum + rx_byte;
        byte_position <= byte_position + IDX_W'(1);
      end else begin
        // checksum byte ends the frame either way
        in_frame      <= 1'b0;
        byte_position <= '0;
      end
    end
  end

  // run read counter
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= '0;
    end else begin
      rd_cnt <= rd_cnt_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_any) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_any) begin
      out_result.id <= frame_id;
      if (cmd.load) begin
        out_result.kind <= KIND_PAYLOAD;
        out_result.data <= rd_data;
        out_result.idx  <= rd_cnt;
        out_result.last <= stat.run_last;
      end else begin
        out_result.kind <= err_len ? KIND_LEN_ERR : KIND_CSUM_ERR;
        out_result.data <= '0;
        out_result.idx  <= '0;
        out_result.last <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/servo_reply_frame_receiver.sv =====
// An error result is registered at the edge that takes its byte and shows next cycle.
// After a good checksum the run passes the read and load states, then 1 byte per cycle while taken.
// Throughput: 1 received byte per cycle while the output is free; a good checksum pauses input
// for a read setup state and a load per payload byte (one buffer read port, one output register).
// Reset (rst, synchronous): hunting restarts and the output empties; buffer contents are kept.
// ---------------------------------------------------------------------------
// servo_reply_frame_receiver
// Deframes serial servo replies (0x55 0x55 id len cmd params csum), checks
// the inverted-sum checksum and streams the cmd/param bytes or an error.
// ---------------------------------------------------------------------------
`include "servo_reply_frame_receiver_macros.svh"

module servo_reply_frame_receiver #(
  parameter int unsigned BUF_BYTES = 32   // payload buffer depth, 8..64
) (
  input  logic        clk,
  input  logic        rst,
  // received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] servo_id, [15:8] data_byte,
                                      // [21:16] byte_index, [23:22] zero
  output logic        m_axis_tlast,   // last result of a run
  output logic [1:0]  m_axis_tuser    // [1:0] result_kind
);
  import srfr_pkg::*;

  srfr_cmd_t    cmd;
  srfr_stat_t   stat;
  srfr_result_t res;

  // sequencer: receive mode or draining a buffered payload run
  srfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // frame registers, checksum, buffer and output register
  srfr_datapath #(
    .BUF_BYTES (BUF_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (s_axis_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_result (res)
  );

  assign m_axis_tdata = {2'b00, res.idx, res.data, res.id};
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = res.kind;

  // error results are single-transfer runs with cleared payload fields
  `SRFR_ASSERT_IMP(a_err_shape, m_axis_tvalid && (m_axis_tuser != KIND_PAYLOAD), m_axis_tlast && (res.data == 8'd0) && (res.idx == '0), "error result with payload fields set")
  // never take a byte while a waiting result cannot move
  `SRFR_ASSERT_IMP(a_no_overrun, s_axis_tready, !m_axis_tvalid || m_axis_tready, "input taken while output stalled")
  // mid-run, input stays closed
  `SRFR_ASSERT_IMP(a_run_blocks, m_axis_tvalid && (m_axis_tuser == KIND_PAYLOAD) && !m_axis_tlast, !s_axis_tready, "input opened inside a payload run")

endmodule

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for servo_reply_frame_receiver. A driver streams
// received bytes (directed corner frames, then random frames and noise)
// and a deframer model predicts every payload run and error result.
// A monitor compares each result transfer against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srfr_pkg::*;

  localparam int unsigned BUF_BYTES = 32;
  localparam int unsigned RAND_BYTES = 265;

  // one queued byte for the driver
  typedef struct {
    logic [7:0]  rx;
    int unsigned gap;   // idle cycles before the byte is offered
    bit          sync;  // hold the byte until all predicted results are in
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;

  servo_reply_frame_receiver #(
    .BUF_BYTES(BUF_BYTES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // [7:0] rx_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),    // [7:0] servo_id, [15:8] data_byte,
                                      // [21:16] byte_index, [23:22] zero
    .m_axis_tlast  (m_axis_tlast),    // last result of a run
    .m_axis_tuser  (m_axis_tuser)     // [1:0] result_kind
  );

  always #6 clk = ~clk;

  // -------------------------------------------------------------------------
  // Deframer model: own copy of the receive state
  // -------------------------------------------------------------------------
  bit           hdr_half;             // one 0x55 seen while hunting
  bit           framing;              // header pair seen, inside a frame
  logic [5:0]   pos;                  // frame index of the next byte
  logic [7:0]   flen;                 // length byte of the frame
  logic [7:0]   csum;                 // low byte of id + len + payload
  logic [7:0]   fid;                  // id byte of the frame
  logic [7:0]   pbuf [BUF_BYTES];     // payload bytes by frame index

  srfr_result_t reply_q[$];           // predicted results, oldest first
  rx_item_t     byte_q[$];            // bytes waiting for the driver
  int unsigned  errors = 0;

  task automatic restart_hunt();
    framing  = 1'b0;
    hdr_half = 1'b0;
    pos      = '0;
    flen     = 8'd2;
  endtask

  task automatic push_reply(input logic [1:0] kind, input logic [7:0] data,
                            input logic [5:0] idx, input logic last);
    srfr_result_t r;
    r.kind = kind;
    r.id   = fid;
    r.data = data;
    r.idx  = idx;
    r.last = last;
    reply_q.push_back(r);
  endtask

  // advance the model by one accepted byte
  task automatic deframe_byte(input logic [7:0] b);
    int unsigned cnt;
    if (!framing) begin
      if (b == HDR_BYTE) begin
        if (hdr_half) begin
          hdr_half = 1'b0;
          framing  = 1'b1;
          pos      = 6'd2;
          flen     = 8'd2;
          csum     = '0;
        end else begin
          hdr_half = 1'b1;
        end
      end else begin
        hdr_half = 1'b0;
      end
    end else if (pos == 6'd2) begin
      fid  = b;
      csum = b;
      pos  = 6'd3;
    end else if (pos == 6'd3) begin
      if (b < MIN_LEN) begin
        restart_hunt();                     // short length: silent drop
      end else if (int'(b) > BUF_BYTES - 3) begin
        push_reply(KIND_LEN_ERR, 8'h00, 6'd0, 1'b1);
        restart_hunt();
      end else begin
        flen = b;
        csum = csum + b;
        pos  = 6'd4;
      end
    end else if (int'(pos) < int'(flen) + 2) begin
      pbuf[pos] = b;
      csum      = csum + b;
      pos       = pos + 6'd1;
    end else begin
      // checksum byte
      if (~csum == b) begin
        cnt = flen - 2;
        for (int unsigned k = 0; k < cnt; k++)
          push_reply(KIND_PAYLOAD, pbuf[4 + k], 6'(k), k + 1 == cnt);
      end else begin
        push_reply(KIND_CSUM_ERR, 8'h00, 6'd0, 1'b1);
      end
      restart_hunt();
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // -------------------------------------------------------------------------
  // Stimulus building
  // -------------------------------------------------------------------------
  int unsigned pushed = 0;
  bit          burst = 1'b0;      // no idle gaps while set
  bit          sync_next = 1'b0;  // next byte waits for all results

  task automatic push_byte(input logic [7:0] b);
    rx_item_t it;
    it.rx   = b;
    it.gap  = burst ? 0 : $urandom_range(0, 13);
    it.sync = sync_next;
    sync_next = 1'b0;
    byte_q.push_back(it);
    pushed++;
  endtask

  // full frame; a nonzero csum_flip corrupts the checksum byte
  task automatic push_frame(input logic [7:0] id, input logic [7:0] len,
                            input logic [7:0] csum_flip);
    logic [7:0] sum;
    logic [7:0] b;
    push_byte(HDR_BYTE);
    push_byte(HDR_BYTE);
    push_byte(id);
    push_byte(len);
    sum = id + len;
    for (int k = 0; k < int'(len) - 2; k++) begin
      b = 8'($urandom);
      sum = sum + b;
      push_byte(b);
    end
    push_byte(~sum ^ csum_flip);
  endtask

  // header, id and a length byte only
  task automatic push_head(input logic [7:0] id, input logic [7:0] len);
    push_byte(HDR_BYTE);
    push_byte(HDR_BYTE);
    push_byte(id);
    push_byte(len);
  endtask

  // -------------------------------------------------------------------------
  // Driver: offers queued bytes, predicts on every accepted transfer
  // -------------------------------------------------------------------------
  int unsigned gap_left = 0;
  bit          head_delayed = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= 0;
      head_delayed  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        deframe_byte(s_axis_tdata);
      // a byte still on offer keeps valid and data unchanged
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left != 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left      <= gap_left - 1;
        end else if (byte_q.size() != 0 && !(byte_q[0].sync && reply_q.size() != 0)) begin
          if (!head_delayed && byte_q[0].gap != 0) begin
            s_axis_tvalid <= 1'b0;
            gap_left      <= byte_q[0].gap - 1;
            head_delayed  <= 1'b1;
          end else begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= byte_q[0].rx;
            head_delayed  <= 1'b0;
            void'(byte_q.pop_front());
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: result checks and receiver back-pressure
  // -------------------------------------------------------------------------
  int unsigned  n_results = 0;
  int unsigned  stall_left = 0;
  int unsigned  wait_draw;
  srfr_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (reply_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 0);
      end else begin
        want = reply_q.pop_front();
        if (m_axis_tuser != want.kind)
          report_mismatch("result_kind", m_axis_tuser, want.kind);
        if (m_axis_tdata[7:0] != want.id)
          report_mismatch("servo_id", m_axis_tdata[7:0], want.id);
        if (m_axis_tdata[15:8] != want.data)
          report_mismatch("data_byte", m_axis_tdata[15:8], want.data);
        if (m_axis_tdata[21:16] != want.idx)
          report_mismatch("byte_index", m_axis_tdata[21:16], want.idx);
        if (m_axis_tlast != want.last)
          report_mismatch("last", m_axis_tlast, want.last);
      end
      n_results <= n_results + 1;
      // long hold-offs let the block fill up and stall its input
      if (n_results == 20 || n_results == 160)
        wait_draw = 300;
      else if ((n_results / 48) % 3 == 1)
        wait_draw = 0;
      else
        wait_draw = $urandom_range(0, 13);
      m_axis_tready <= (wait_draw == 0);
      stall_left    <= wait_draw;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // -------------------------------------------------------------------------
  initial begin
    int unsigned sel;
    int unsigned frames;
    int unsigned directed_end;

    restart_hunt();
    csum = '0;
    fid  = '0;

    // directed corners
    push_byte(8'h00);                     // noise while hunting
    push_byte(8'hFF);
    push_byte(HDR_BYTE);                  // lone header byte cleared by noise
    push_byte(8'hAA);
    push_frame(HDR_BYTE, 8'd3, 8'h00);    // third 0x55 is the id; cmd only
    push_head(8'h00, 8'd0);               // short lengths dropped
    push_head(8'hFF, 8'd2);
    push_head(8'h12, 8'd30);              // one past the buffer bound
    push_head(8'h34, 8'd255);
    push_frame(8'hFF, 8'd4, 8'h80);       // checksum mismatch
    push_frame(8'h00, 8'd29, 8'h00);      // longest frame that fits
    directed_end = pushed;

    // random frames, mostly well formed
    frames = 0;
    while (pushed < directed_end + RAND_BYTES) begin
      burst = ((pushed / 40) % 3 == 2);
      if (frames % 12 == 0)
        sync_next = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 60)
        push_frame(8'($urandom), 8'($urandom_range(3, 12)), 8'h00);
      else if (sel < 70)
        push_frame(8'($urandom), 8'($urandom_range(13, BUF_BYTES - 3)), 8'h00);
      else if (sel < 80)
        push_frame(8'($urandom), 8'($urandom_range(3, 12)), 8'($urandom_range(1, 255)));
      else if (sel < 85)
        push_head(8'($urandom), 8'($urandom_range(BUF_BYTES - 2, 255)));
      else if (sel < 90)
        push_head(8'($urandom), 8'($urandom_range(0, 2)));
      else
        repeat ($urandom_range(1, 4))
          push_byte($urandom_range(0, 3) == 0 ? HDR_BYTE : 8'($urandom));
      frames++;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (!(byte_q.size() == 0 && !s_axis_tvalid && reply_q.size() == 0))
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
